@@ design/slq_pkg.sv @@
// slq_pkg: constants, segment tables and inter-stage types of the log quantiser.
// No dependencies; imported by every module of the block.
`default_nettype none

package slq_pkg;

  localparam int RndBits    = 16;
  localparam int RndW       = 16;
  localparam int SegCnt     = 21;
  localparam int SegW       = 5;
  localparam int StepW      = 9;
  localparam int OffW       = 12;
  localparam int QW         = 4;
  localparam int LevelW     = 14;
  localparam int ProdW      = RndW + StepW;
  localparam int SmallLimit = 50;
  localparam int SatValue   = 13140;
  localparam int SegCodes   = 10;
  localparam int MaxCode    = 255;
  localparam logic [RndW-1:0] RndMask = RndW'((64'd1 << RndBits) - 64'd1);

  typedef logic [SegW-1:0] seg_t;

  function automatic logic [LevelW-1:0] seg_start(input seg_t i);
    logic [LevelW-1:0] s;
    case (i)
      5'd0:    s = 14'd50;
      5'd1:    s = 14'd70;
      5'd2:    s = 14'd100;
      5'd3:    s = 14'd140;
      5'd4:    s = 14'd190;
      5'd5:    s = 14'd250;
      5'd6:    s = 14'd320;
      5'd7:    s = 14'd400;
      5'd8:    s = 14'd490;
      5'd9:    s = 14'd590;
      5'd10:   s = 14'd740;
      5'd11:   s = 14'd940;
      5'd12:   s = 14'd1190;
      5'd13:   s = 14'd1490;
      5'd14:   s = 14'd1890;
      5'd15:   s = 14'd2390;
      5'd16:   s = 14'd3140;
      5'd17:   s = 14'd4140;
      5'd18:   s = 14'd5640;
      5'd19:   s = 14'd7640;
      5'd20:   s = 14'd10640;
      default: s = 14'd10640;
    endcase
    return s;
  endfunction

  function automatic logic [StepW-1:0] seg_step(input seg_t i);
    logic [StepW-1:0] s;
    case (i)
      5'd0:    s = 9'd2;
      5'd1:    s = 9'd3;
      5'd2:    s = 9'd4;
      5'd3:    s = 9'd5;
      5'd4:    s = 9'd6;
      5'd5:    s = 9'd7;
      5'd6:    s = 9'd8;
      5'd7:    s = 9'd9;
      5'd8:    s = 9'd10;
      5'd9:    s = 9'd15;
      5'd10:   s = 9'd20;
      5'd11:   s = 9'd25;
      5'd12:   s = 9'd30;
      5'd13:   s = 9'd40;
      5'd14:   s = 9'd50;
      5'd15:   s = 9'd75;
      5'd16:   s = 9'd100;
      5'd17:   s = 9'd150;
      5'd18:   s = 9'd200;
      5'd19:   s = 9'd300;
      5'd20:   s = 9'd500;
      default: s = 9'd500;
    endcase
    return s;
  endfunction

  // after segment search
  typedef struct packed {
    logic            kind;
    logic            direct;
    logic            sat;
    seg_t            seg;
    logic [OffW-1:0] off;   // offset into segment, or code offset on decode
    logic [RndW-1:0] rnd;
    logic [7:0]      code;  // pass-through code/value below the first segment
  } s1_t;

  // after quotient search
  typedef struct packed {
    logic             kind;
    logic             direct;
    logic             sat;
    seg_t             seg;
    logic [OffW-1:0]  off;
    logic [QW-1:0]    q;
    logic [ProdW-1:0] prod;
    logic [7:0]       code;
  } s2_t;

  // after remainder and level
  typedef struct packed {
    logic              kind;
    logic              direct;
    logic              sat;
    logic [7:0]        base;
    logic [StepW-1:0]  rem;
    logic [LevelW-1:0] level;
    logic [ProdW-1:0]  prod;
    logic [7:0]        code;
  } s3_t;

endpackage

`default_nettype wire

@@ design/slq_in_if.sv @@
// slq_in_if: input word channel of the log quantiser.
// No dependencies.
`default_nettype none

interface slq_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] raw_value;
  logic [15:0] rnd_fraction;
  logic [7:0]  code_in;

  modport source (output valid, kind, raw_value, rnd_fraction, code_in, input ready);
  modport sink   (input valid, kind, raw_value, rnd_fraction, code_in, output ready);
endinterface

`default_nettype wire

@@ design/slq_out_if.sv @@
// slq_out_if: result word channel of the log quantiser.
// No dependencies.
`default_nettype none

interface slq_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  code_out;
  logic [13:0] value_out;

  modport source (output valid, code_out, value_out, input ready);
  modport sink   (input valid, code_out, value_out, output ready);
endinterface

`default_nettype wire

@@ design/stochastic_log_quantizer_8bit.sv @@
// stochastic_log_quantizer_8bit: top level, stage chain plus rounding/output stage.
// Depends on slq_pkg, slq_in_if, slq_out_if, slq_locate, slq_divide.
//
//   port   dir  word
//   in_i   in   kind, raw_value, rnd_fraction, code_in
//   out_o  out  code_out, value_out
//
// One word per cycle while out_o is not stalled; four register stages lie between in_i
// and out_o. The whole chain advances together whenever the output register is empty
// or being read; a stall at out_o freezes every stage. rst_ni clears all valid bits;
// the curve tables are constant logic.
`default_nettype none

module stochastic_log_quantizer_8bit
  import slq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  slq_in_if.sink     in_i,
  slq_out_if.source  out_o
);

  logic              en;
  logic              valid1, valid3;
  s1_t               s1;
  s3_t               s3;
  logic              out_valid_q;
  logic [7:0]        code_d, code_q;
  logic [LevelW-1:0] value_d, value_q;
  logic              up;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  slq_locate u_locate (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (in_i.valid),
    .kind_i         (in_i.kind),
    .raw_value_i    (in_i.raw_value),
    .rnd_fraction_i (in_i.rnd_fraction),
    .code_in_i      (in_i.code_in),
    .valid_o        (valid1),
    .s1_o           (s1)
  );

  slq_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid1),
    .s1_i    (s1),
    .valid_o (valid3),
    .s3_o    (s3)
  );

  // round up when rnd * step < rem * 2^RndBits
  always_comb begin
    up = s3.prod < ProdW'({s3.rem, RndW'(0)} >> (RndW - RndBits));
    if (s3.kind) begin
      code_d  = '0;
      value_d = s3.direct ? LevelW'(s3.code) : s3.level;
    end else begin
      value_d = '0;
      if (s3.direct)     code_d = s3.code;
      else if (s3.sat)   code_d = 8'(MaxCode);
      else               code_d = s3.base + 8'(up);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      code_q  <= code_d;
      value_q <= value_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.code_out  = code_q;
  assign out_o.value_out = value_q;

endmodule

`default_nettype wire

@@ design/slq_locate.sv @@
// slq_locate: stage 1, finds the curve segment of a value or code and its offset.
// Depends on slq_pkg.
`default_nettype none

module slq_locate
  import slq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic        kind_i,
  input  wire logic [31:0] raw_value_i,
  input  wire logic [15:0] rnd_fraction_i,
  input  wire logic [7:0]  code_in_i,
  output logic             valid_o,
  output s1_t              s1_o
);

  s1_t  s1_d, s1_q;
  logic valid_q;
  seg_t seg_r, seg_c;
  logic [LevelW-1:0] r14;
  logic [LevelW-1:0] off_r;
  logic [7:0]        off_c;

  always_comb begin
    r14   = raw_value_i[LevelW-1:0];
    seg_r = '0;
    seg_c = '0;
    for (int i = 1; i < SegCnt; i++) begin
      if (r14 >= seg_start(seg_t'(i))) seg_r = seg_t'(i);
      if (code_in_i >= 8'(SmallLimit + SegCodes * i)) seg_c = seg_t'(i);
    end
    off_r = r14 - seg_start(seg_r);
    off_c = code_in_i - (8'(SmallLimit) + 8'({3'b0, seg_c} * 8'(SegCodes)));

    s1_d.kind = kind_i;
    s1_d.rnd  = rnd_fraction_i & RndMask;
    if (kind_i) begin
      s1_d.direct = code_in_i < 8'(SmallLimit);
      s1_d.sat    = 1'b0;
      s1_d.seg    = seg_c;
      s1_d.off    = OffW'(off_c);
      s1_d.code   = code_in_i;
    end else begin
      s1_d.direct = raw_value_i < 32'(SmallLimit);
      s1_d.sat    = raw_value_i >= 32'(SatValue);
      s1_d.seg    = seg_r;
      s1_d.off    = off_r[OffW-1:0];
      s1_d.code   = {2'b0, raw_value_i[5:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;

endmodule

`default_nettype wire

@@ design/slq_divide.sv @@
// slq_divide: stages 2 and 3, quotient by compare against step multiples,
// then remainder, segment level and lower code. Depends on slq_pkg.
`default_nettype none

module slq_divide
  import slq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  wire s1_t  s1_i,
  output logic      valid_o,
  output s3_t       s3_o
);

  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  logic valid2_q, valid3_q;
  logic [StepW-1:0]  step1, step2;
  logic [QW-1:0]     cnt;
  logic [12:0]       qs;

  // stage 2
  always_comb begin
    step1 = seg_step(s1_i.seg);
    cnt   = '0;
    for (int k = 1; k < SegCodes; k++) begin
      if (13'(s1_i.off) >= 13'(k) * 13'(step1)) cnt = cnt + 1'b1;
    end
    s2_d.kind   = s1_i.kind;
    s2_d.direct = s1_i.direct;
    s2_d.sat    = s1_i.sat;
    s2_d.seg    = s1_i.seg;
    s2_d.off    = s1_i.off;
    s2_d.q      = s1_i.kind ? s1_i.off[QW-1:0] : cnt;
    s2_d.prod   = ProdW'(s1_i.rnd) * ProdW'(step1);
    s2_d.code   = s1_i.code;
  end

  // stage 3
  always_comb begin
    step2       = seg_step(s2_q.seg);
    qs          = 13'(s2_q.q) * 13'(step2);
    s3_d.kind   = s2_q.kind;
    s3_d.direct = s2_q.direct;
    s3_d.sat    = s2_q.sat;
    s3_d.base   = 8'(SmallLimit) + 8'({3'b0, s2_q.seg} * 8'(SegCodes)) + 8'(s2_q.q);
    s3_d.rem    = StepW'(13'(s2_q.off) - qs);
    s3_d.level  = seg_start(s2_q.seg) + LevelW'(qs);
    s3_d.prod   = s2_q.prod;
    s3_d.code   = s2_q.code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else if (en_i) begin
      valid2_q <= valid_i;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  assign valid_o = valid3_q;
  assign s3_o    = s3_q;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// testbench: self-checking bench for stochastic_log_quantizer_8bit; a directed table, then
// random words under four idling regimes, every result checked against an in-bench curve model.
// Depends on slq_pkg, slq_in_if, slq_out_if and the block itself.
`default_nettype none

module testbench;
  import slq_pkg::*;

  localparam int unsigned PassBelow   = 50;
  localparam int unsigned SatLevel    = 13140;
  localparam int unsigned FracBits    = 16;
  localparam int          RandWords   = 1500;
  localparam int          PhaseCnt    = 4;
  localparam int          IdleLimit   = 1000;
  localparam int          DrainCycles = 8;
  localparam int          ShowLimit   = 10;

  typedef enum logic {OP_COMPRESS = 1'b0, OP_EXPAND = 1'b1} op_e;

  typedef struct {
    op_e               op;
    logic [31:0]       raw;
    logic [15:0]       frac;
    logic [7:0]        code;
    bit                fixed;
    logic [7:0]        want_code;
    logic [LevelW-1:0] want_value;
  } table_row_t;

  typedef struct packed {
    logic [7:0]        code;
    logic [LevelW-1:0] value;
  } result_t;

  logic clk_i;
  logic rst_ni;

  slq_in_if  word_in ();
  slq_out_if word_out ();

  stochastic_log_quantizer_8bit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (word_in),
    .out_o  (word_out)
  );

  int unsigned curve_lvl [256];
  result_t     pending_results [$];
  table_row_t  directed_rows [$];
  int          sender_idle_pct    = 0;
  int          receiver_stall_pct = 0;
  int          bad_words          = 0;
  int          idle_cycles        = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // distance from code c to code c+1 along the curve
  function automatic int unsigned code_pitch(int unsigned c);
    if (c < PassBelow) return 1;
    case ((c - PassBelow) / 10)
      0:       return 2;
      1:       return 3;
      2:       return 4;
      3:       return 5;
      4:       return 6;
      5:       return 7;
      6:       return 8;
      7:       return 9;
      8:       return 10;
      9:       return 15;
      10:      return 20;
      11:      return 25;
      12:      return 30;
      13:      return 40;
      14:      return 50;
      15:      return 75;
      16:      return 100;
      17:      return 150;
      18:      return 200;
      19:      return 300;
      default: return 500;
    endcase
  endfunction

  function automatic void build_curve();
    int unsigned c;
    curve_lvl[0] = 0;
    for (c = 1; c < 256; c++) curve_lvl[c] = curve_lvl[c-1] + code_pitch(c - 1);
  endfunction

  function automatic result_t quantise_word(op_e op, logic [31:0] raw, logic [15:0] frac,
                                            logic [7:0] code);
    result_t         res;
    int unsigned     lo;
    longint unsigned rem;
    longint unsigned span;
    res = '0;
    if (op == OP_EXPAND) begin
      res.value = LevelW'(curve_lvl[code]);
    end else if (raw < PassBelow) begin
      res.code = raw[7:0];
    end else if (raw >= SatLevel) begin
      res.code = 8'hFF;
    end else begin
      lo = 254;
      while (curve_lvl[lo] > raw) lo--;
      rem  = raw - curve_lvl[lo];
      span = curve_lvl[lo+1] - curve_lvl[lo];
      res.code = 8'(lo);
      // round up with probability rem/span
      if (span != 0 && 64'(frac) * span < (rem << FracBits)) res.code = 8'(lo + 1);
    end
    return res;
  endfunction

  function automatic void add_row(op_e op, logic [31:0] raw, logic [15:0] frac,
                                  logic [7:0] code, bit fixed, logic [7:0] want_code,
                                  logic [LevelW-1:0] want_value);
    table_row_t r;
    r.op         = op;
    r.raw        = raw;
    r.frac       = frac;
    r.code       = code;
    r.fixed      = fixed;
    r.want_code  = want_code;
    r.want_value = want_value;
    directed_rows.push_back(r);
  endfunction

  task automatic send_word(input table_row_t w);
    result_t want;
    while ($urandom_range(99) < sender_idle_pct) begin
      word_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    word_in.valid        <= 1'b1;
    word_in.kind         <= w.op;
    word_in.raw_value    <= w.raw;
    word_in.rnd_fraction <= w.frac;
    word_in.code_in      <= w.code;
    @(posedge clk_i);
    while (!word_in.ready) @(posedge clk_i);
    if (w.fixed) begin
      want.code  = w.want_code;
      want.value = w.want_value;
    end else begin
      want = quantise_word(w.op, w.raw, w.frac, w.code);
    end
    pending_results.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    table_row_t  w;
    int unsigned c;
    w.op    = ($urandom_range(99) < 60) ? OP_COMPRESS : OP_EXPAND;
    w.code  = 8'($urandom());
    w.fixed = 1'b0;
    w.want_code  = '0;
    w.want_value = '0;
    c = $urandom_range(255, PassBelow - 1);
    case ($urandom_range(9))
      0, 1, 2, 3: w.raw = $urandom_range(SatLevel - 1);
      4, 5:       w.raw = curve_lvl[c] + $urandom_range(2) - 1;  // around a level
      6:          w.raw = $urandom_range(PassBelow - 1);
      7:          w.raw = SatLevel + $urandom_range(1000);
      default:    w.raw = $urandom();
    endcase
    case ($urandom_range(3))
      0:       w.frac = '0;
      1:       w.frac = '1;
      default: w.frac = 16'($urandom());
    endcase
    send_word(w);
  endtask

  initial begin
    int phase;
    rst_ni               <= 1'b0;
    word_in.valid        <= 1'b0;
    word_in.kind         <= OP_COMPRESS;
    word_in.raw_value    <= '0;
    word_in.rnd_fraction <= '0;
    word_in.code_in      <= '0;
    build_curve();

    add_row(OP_COMPRESS, 32'd0,          16'h0000, 8'h00, 1'b1, 8'd0,   14'd0);
    add_row(OP_COMPRESS, 32'd49,         16'hFFFF, 8'hFF, 1'b1, 8'd49,  14'd0);
    add_row(OP_COMPRESS, 32'd50,         16'h0000, 8'h00, 1'b1, 8'd50,  14'd0);
    add_row(OP_COMPRESS, 32'd51,         16'h0000, 8'h00, 1'b0, 8'd0,   14'd0);
    add_row(OP_COMPRESS, 32'd51,         16'hFFFF, 8'h00, 1'b0, 8'd0,   14'd0);
    add_row(OP_COMPRESS, 32'd89,         16'h7FFF, 8'h00, 1'b0, 8'd0,   14'd0);
    add_row(OP_COMPRESS, 32'd1000,       16'h8000, 8'h00, 1'b0, 8'd0,   14'd0);
    add_row(OP_COMPRESS, 32'd7640,       16'h0001, 8'h00, 1'b1, 8'd240, 14'd0);
    add_row(OP_COMPRESS, 32'd10639,      16'h0000, 8'h00, 1'b0, 8'd0,   14'd0);
    add_row(OP_COMPRESS, 32'd10640,      16'hFFFF, 8'h00, 1'b1, 8'd250, 14'd0);
    add_row(OP_COMPRESS, 32'd12640,      16'hFFFF, 8'h00, 1'b1, 8'd254, 14'd0);
    add_row(OP_COMPRESS, 32'd13139,      16'h0000, 8'h00, 1'b0, 8'd0,   14'd0);
    add_row(OP_COMPRESS, 32'd13139,      16'hFFFF, 8'h00, 1'b0, 8'd0,   14'd0);
    add_row(OP_COMPRESS, 32'd13140,      16'h0000, 8'h00, 1'b1, 8'd255, 14'd0);
    add_row(OP_COMPRESS, 32'd13141,      16'h1234, 8'h00, 1'b1, 8'd255, 14'd0);
    add_row(OP_COMPRESS, 32'h8000_0000,  16'h0000, 8'h00, 1'b1, 8'd255, 14'd0);
    add_row(OP_COMPRESS, 32'hFFFF_FFFF,  16'hFFFF, 8'hFF, 1'b1, 8'd255, 14'd0);
    add_row(OP_EXPAND,   32'hFFFF_FFFF,  16'hFFFF, 8'd0,  1'b1, 8'd0,   14'd0);
    add_row(OP_EXPAND,   32'd0,          16'h0000, 8'd49, 1'b1, 8'd0,   14'd49);
    add_row(OP_EXPAND,   32'd0,          16'h0000, 8'd50, 1'b1, 8'd0,   14'd50);
    add_row(OP_EXPAND,   32'd0,          16'h0000, 8'd128, 1'b0, 8'd0,  14'd0);
    add_row(OP_EXPAND,   32'd0,          16'h0000, 8'd254, 1'b1, 8'd0,  14'd12640);
    add_row(OP_EXPAND,   32'd13140,      16'hFFFF, 8'd255, 1'b1, 8'd0,  14'd13140);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed_rows[i]) send_word(directed_rows[i]);

    for (phase = 0; phase < PhaseCnt; phase++) begin
      // hold off until the pipe has drained
      word_in.valid <= 1'b0;
      @(negedge clk_i);
      while (pending_results.size() != 0) @(negedge clk_i);
      case (phase)
        0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1:       begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
        default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
      endcase
      repeat (RandWords / PhaseCnt) send_random();
    end
    word_in.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (bad_words == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    word_out.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && word_out.valid && word_out.ready) begin
      if (pending_results.size() == 0) begin
        bad_words++;
        if (bad_words <= ShowLimit)
          $display("unexpected word: code_out %0d value_out %0d",
                   word_out.code_out, word_out.value_out);
      end else begin
        want = pending_results.pop_front();
        if (want.code !== word_out.code_out || want.value !== word_out.value_out) begin
          bad_words++;
          if (bad_words <= ShowLimit)
            $display("mismatch: code_out exp %0d got %0d, value_out exp %0d got %0d",
                     want.code, word_out.code_out, want.value, word_out.value_out);
        end
      end
    end
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

`default_nettype wire

@@ files.f @@
design/slq_pkg.sv
design/slq_in_if.sv
design/slq_out_if.sv
design/slq_locate.sv
design/slq_divide.sv
design/stochastic_log_quantizer_8bit.sv
sim/testbench.sv
